FILE: hw/rtl/gfr_pkg.sv
package gfr_pkg;

    localparam int GFR_SCREEN_WIDTH  = 128;
    localparam int GFR_SCREEN_HEIGHT = 64;
    localparam int GFR_FONT_DEPTH    = 2048;

    localparam logic [7:0] FIRST_CODE = 8'd32;
    localparam logic [7:0] LAST_CODE  = 8'd126;
    localparam logic [7:0] BYTE_ONES  = 8'hFF;

    typedef enum logic [2:0] {
        FN_LOAD_FONT  = 3'd0,
        FN_SET_CURSOR = 3'd1,
        FN_WRITE_CHAR = 3'd2,
        FN_DRAW_PIXEL = 3'd3,
        FN_FILL       = 3'd4,
        FN_READ_BYTE  = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        CFG_GLYPH_WIDTH  = 2'd0,
        CFG_GLYPH_HEIGHT = 2'd1,
        CFG_INVERT       = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        FOP_NONE,
        FOP_PIXEL,
        FOP_READ,
        FOP_SWEEP
    } fop_t;

    typedef enum logic [1:0] {
        U_IDLE,
        U_MODIFY,
        U_SWEEP
    } unit_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FONT,
        ST_PIX,
        ST_DOT,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       start;
        fop_t       op;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
        logic [9:0] byte_index;
    } frame_cmd_t;

    typedef struct packed {
        logic       ready;
        logic       done;
        logic [7:0] rd_byte;
    } frame_sts_t;

endpackage

FILE: hw/rtl/glyph_framebuffer_renderer.sv
// Cursor, font load and rejected non-character items go from the accepted beat to the result.
// Draw pixel and read byte make one frame access; a character stops after the check when rejected
// or of zero glyph size, else each glyph row reads its font row, then one read-modify-write per pixel.
// Fill writes every byte of the frame, one byte written per cycle.
// One item at a time: the next input beat is taken after the result is registered.
// After reset the frame is cleared by a sweep, with input stalled.
module glyph_framebuffer_renderer #(
    parameter int SCREEN_WIDTH  = gfr_pkg::GFR_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = gfr_pkg::GFR_SCREEN_HEIGHT,
    parameter int FONT_DEPTH    = gfr_pkg::GFR_FONT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [7:0]  pos_x,
    input  logic [7:0]  pos_y,
    input  logic [7:0]  char_code,
    input  logic        pen_color,
    input  logic [10:0] font_address,
    input  logic [15:0] font_row,
    input  logic [9:0]  byte_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [7:0]  frame_byte,
    output logic [7:0]  cursor_col,
    output logic [7:0]  cursor_row,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import gfr_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int FAW         = $clog2(FONT_DEPTH);
    localparam logic [12:0] FRAME_LIM = 13'(FRAME_BYTES);
    localparam logic [12:0] FONT_LIM  = 13'(FONT_DEPTH);
    localparam logic [8:0]  SW9       = 9'(SCREEN_WIDTH);
    localparam logic [8:0]  SH9       = 9'(SCREEN_HEIGHT);

    state_t      state_reg, state_next;
    logic [7:0]  cursor_x_reg, cursor_x_next;
    logic [7:0]  cursor_y_reg, cursor_y_next;
    logic [4:0]  col_reg, col_next;
    logic [4:0]  row_reg, row_next;
    logic [4:0]  gw_reg;
    logic [4:0]  gh_reg;
    logic        inv_reg;
    logic        out_valid_reg;

    logic        pen_reg, pen_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  dot_x_reg, dot_x_next;
    logic [7:0]  dot_y_reg, dot_y_next;
    logic [9:0]  bidx_reg, bidx_next;
    logic        status_reg, status_next;
    logic [7:0]  rd_byte_reg, rd_byte_next;
    logic [11:0] base_reg, base_next;
    logic        font_ok_reg;
    logic [15:0] font_q_reg;
    logic        status_out_reg;
    logic [7:0]  frame_byte_out_reg;
    logic [7:0]  cursor_col_out_reg;
    logic [7:0]  cursor_row_out_reg;

    logic [15:0] font_mem [FONT_DEPTH];

    logic        in_accept;
    logic        load_out;
    logic        font_we;
    logic        font_addr_ok;
    logic        byte_ok;
    logic        off_screen;
    logic [11:0] font_raddr;
    logic [7:0]  code_off;
    logic        reject;
    logic        empty_cell;
    logic        last_col;
    logic        last_row;
    logic        glyph_bit;
    logic [7:0]  pix_x;
    logic [7:0]  pix_y;

    frame_cmd_t  fcmd;
    frame_sts_t  fsts;

    gfr_frame_unit #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_frame (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (fcmd),
        .sts  (fsts)
    );

    assign in_stall     = !(state_reg == ST_IDLE && fsts.ready);
    assign in_accept    = in_valid && !in_stall;
    assign load_out     = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign font_addr_ok = {2'b00, font_address} < FONT_LIM;
    assign font_we      = in_accept && (func == FN_LOAD_FONT) && font_addr_ok;
    assign byte_ok      = {3'b000, byte_index} < FRAME_LIM;
    assign off_screen   = ({1'b0, pos_x} >= SW9) || ({1'b0, pos_y} >= SH9);
    assign font_raddr   = base_reg + {7'b0, row_reg};
    assign code_off     = code_reg - FIRST_CODE;
    assign reject       = (code_reg < FIRST_CODE) || (code_reg > LAST_CODE)
                          || (({1'b0, cursor_x_reg} + {4'b0, gw_reg}) > SW9)
                          || (({1'b0, cursor_y_reg} + {4'b0, gh_reg}) > SH9);
    assign empty_cell   = (gw_reg == 5'd0) || (gh_reg == 5'd0);
    assign last_col     = col_reg == (gw_reg - 5'd1);
    assign last_row     = row_reg == (gh_reg - 5'd1);
    assign glyph_bit    = font_ok_reg && !col_reg[4] && font_q_reg[~col_reg[3:0]];
    assign pix_x        = cursor_x_reg + {3'b000, col_reg};
    assign pix_y        = cursor_y_reg + {3'b000, row_reg};

    assign out_valid  = out_valid_reg;
    assign status     = status_out_reg;
    assign frame_byte = frame_byte_out_reg;
    assign cursor_col = cursor_col_out_reg;
    assign cursor_row = cursor_row_out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (func)
                        FN_WRITE_CHAR: state_next = ST_CHECK;
                        FN_DRAW_PIXEL: state_next = off_screen ? ST_DONE : ST_DOT;
                        FN_FILL:       state_next = ST_FILL;
                        FN_READ_BYTE:  state_next = byte_ok ? ST_READ : ST_DONE;
                        default:       state_next = ST_DONE;
                    endcase
                end
            end
            ST_CHECK: state_next = (reject || empty_cell) ? ST_DONE : ST_FONT;
            ST_FONT:  state_next = ST_PIX;
            ST_PIX:
            begin
                if (fsts.done && last_col)
                begin
                    state_next = last_row ? ST_DONE : ST_FONT;
                end
            end
            ST_DOT, ST_FILL, ST_READ:
            begin
                if (fsts.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pen_next      = pen_reg;
        code_next     = code_reg;
        dot_x_next    = dot_x_reg;
        dot_y_next    = dot_y_reg;
        bidx_next     = bidx_reg;
        status_next   = status_reg;
        rd_byte_next  = rd_byte_reg;
        base_next     = base_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pen_next     = pen_color;
                    code_next    = char_code;
                    dot_x_next   = pos_x;
                    dot_y_next   = pos_y;
                    bidx_next    = byte_index;
                    status_next  = 1'b0;
                    rd_byte_next = 8'h00;
                    unique case (func)
                        FN_LOAD_FONT:  status_next = !font_addr_ok;
                        FN_SET_CURSOR:
                        begin
                            cursor_x_next = pos_x;
                            cursor_y_next = pos_y;
                        end
                        FN_WRITE_CHAR: status_next = 1'b0;
                        FN_DRAW_PIXEL: status_next = off_screen;
                        FN_FILL:       status_next = 1'b0;
                        FN_READ_BYTE:  status_next = !byte_ok;
                        default:       status_next = 1'b1;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (reject)
                begin
                    status_next = 1'b1;
                end
                else if (empty_cell)
                begin
                    cursor_x_next = cursor_x_reg + {3'b000, gw_reg};
                end
                else
                begin
                    base_next = {5'b0, code_off[6:0]} * {7'b0, gh_reg};
                    row_next  = 5'd0;
                    col_next  = 5'd0;
                end
            end
            ST_PIX:
            begin
                if (fsts.done)
                begin
                    if (last_col)
                    begin
                        col_next = 5'd0;
                        if (last_row)
                        begin
                            cursor_x_next = cursor_x_reg + {3'b000, gw_reg};
                        end
                        else
                        begin
                            row_next = row_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 5'd1;
                    end
                end
            end
            ST_READ:
            begin
                if (fsts.done)
                begin
                    rd_byte_next = fsts.rd_byte;
                end
            end
            default:
            begin
                base_next = base_reg;
            end
        endcase
    end

    always_comb
    begin
        fcmd.start      = 1'b0;
        fcmd.op         = FOP_NONE;
        fcmd.x          = dot_x_reg;
        fcmd.y          = dot_y_reg;
        fcmd.color      = pen_reg ^ inv_reg;
        fcmd.byte_index = bidx_reg;
        unique case (state_reg)
            ST_PIX:
            begin
                fcmd.start = 1'b1;
                fcmd.op    = FOP_PIXEL;
                fcmd.x     = pix_x;
                fcmd.y     = pix_y;
                fcmd.color = (glyph_bit ~^ pen_reg) ^ inv_reg;
            end
            ST_DOT:
            begin
                fcmd.start = 1'b1;
                fcmd.op    = FOP_PIXEL;
            end
            ST_FILL:
            begin
                fcmd.start = 1'b1;
                fcmd.op    = FOP_SWEEP;
                fcmd.color = pen_reg;
            end
            ST_READ:
            begin
                fcmd.start = 1'b1;
                fcmd.op    = FOP_READ;
            end
            default:
            begin
                fcmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_x_reg  <= 8'd0;
            cursor_y_reg  <= 8'd0;
            col_reg       <= 5'd0;
            row_reg       <= 5'd0;
            gw_reg        <= 5'd7;
            gh_reg        <= 5'd10;
            inv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GLYPH_WIDTH:  gw_reg  <= cfg_data;
                    CFG_GLYPH_HEIGHT: gh_reg  <= cfg_data;
                    CFG_INVERT:       inv_reg <= cfg_data[0];
                    default:          inv_reg <= inv_reg;
                endcase
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pen_reg     <= pen_next;
        code_reg    <= code_next;
        dot_x_reg   <= dot_x_next;
        dot_y_reg   <= dot_y_next;
        bidx_reg    <= bidx_next;
        status_reg  <= status_next;
        rd_byte_reg <= rd_byte_next;
        base_reg    <= base_next;
        if (state_reg == ST_FONT)
        begin
            font_ok_reg <= {1'b0, font_raddr} < FONT_LIM;
        end
        if (load_out)
        begin
            status_out_reg     <= status_reg;
            frame_byte_out_reg <= rd_byte_reg;
            cursor_col_out_reg <= cursor_x_reg;
            cursor_row_out_reg <= cursor_y_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            font_mem[FAW'(font_address)] <= font_row;
        end
        if (state_reg == ST_FONT)
        begin
            font_q_reg <= font_mem[FAW'(font_raddr)];
        end
    end

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("Result beat raised outside the completion state.");

    a_glyph_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PIX |-> (({1'b0, cursor_x_reg} + {4'b0, col_reg}) < SW9)
                                && (({1'b0, cursor_y_reg} + {4'b0, row_reg}) < SH9))
        else $error("Glyph pixel addressed outside the screen.");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != ST_IDLE)
        else $error("Accepted beat did not start any work.");

endmodule

FILE: hw/rtl/gfr_frame_unit.sv
module gfr_frame_unit #(
    parameter int SCREEN_WIDTH  = gfr_pkg::GFR_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = gfr_pkg::GFR_SCREEN_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gfr_pkg::frame_cmd_t cmd,
    output gfr_pkg::frame_sts_t sts
);
    import gfr_pkg::*;

    localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FRAME_BYTES = SCREEN_WIDTH * PAGE_COUNT;
    localparam int AW          = $clog2(FRAME_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(FRAME_BYTES - 1);
    localparam logic [AW-1:0] WIDTH_A   = AW'(SCREEN_WIDTH);

    unit_state_t   state_reg, state_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic          sweep_val_reg, sweep_val_next;
    logic          is_pixel_reg, is_pixel_next;
    logic [AW-1:0] pix_addr_reg, pix_addr_next;
    logic [2:0]    bit_sel_reg, bit_sel_next;
    logic          color_reg, color_next;

    logic [7:0]    mem [FRAME_BYTES];
    logic [7:0]    rd_q_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [7:0]    wdata;
    logic [7:0]    bit_mask;
    logic [AW-1:0] cmd_pix_addr;

    assign cmd_pix_addr = AW'(cmd.y[7:3]) * WIDTH_A + AW'(cmd.x);
    assign bit_mask     = 8'b1 << bit_sel_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (cmd.start)
                begin
                    case (cmd.op) inside
                        FOP_PIXEL, FOP_READ: state_next = U_MODIFY;
                        FOP_SWEEP:           state_next = U_SWEEP;
                        default:             state_next = U_IDLE;
                    endcase
                end
            end
            U_MODIFY: state_next = U_IDLE;
            U_SWEEP:
            begin
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    state_next = U_IDLE;
                end
            end
            default: state_next = U_IDLE;
        endcase
    end

    always_comb
    begin
        sweep_addr_next = sweep_addr_reg;
        sweep_val_next  = sweep_val_reg;
        is_pixel_next   = is_pixel_reg;
        pix_addr_next   = pix_addr_reg;
        bit_sel_next    = bit_sel_reg;
        color_next      = color_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        waddr           = pix_addr_reg;
        raddr           = cmd_pix_addr;
        wdata           = rd_q_reg;
        sts.ready       = 1'b0;
        sts.done        = 1'b0;
        sts.rd_byte     = rd_q_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                sts.ready = 1'b1;
                if (cmd.start && (cmd.op == FOP_PIXEL || cmd.op == FOP_READ))
                begin
                    mem_re        = 1'b1;
                    raddr         = (cmd.op == FOP_READ) ? AW'(cmd.byte_index) : cmd_pix_addr;
                    is_pixel_next = (cmd.op == FOP_PIXEL);
                    pix_addr_next = cmd_pix_addr;
                    bit_sel_next  = cmd.y[2:0];
                    color_next    = cmd.color;
                end
                else if (cmd.start && cmd.op == FOP_SWEEP)
                begin
                    sweep_addr_next = '0;
                    sweep_val_next  = cmd.color;
                end
            end
            U_MODIFY:
            begin
                sts.done = 1'b1;
                if (is_pixel_reg)
                begin
                    mem_we = 1'b1;
                    wdata  = color_reg ? (rd_q_reg | bit_mask) : (rd_q_reg & ~bit_mask);
                end
            end
            U_SWEEP:
            begin
                mem_we = 1'b1;
                waddr  = sweep_addr_reg;
                wdata  = sweep_val_reg ? BYTE_ONES : 8'h00;
                if (sweep_addr_reg == LAST_ADDR)
                begin
                    sts.done = 1'b1;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            default:
            begin
                sts.ready = 1'b0;
            end
        endcase
    end

    // The frame is cleared by a full sweep that starts when reset is released.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= U_SWEEP;
            sweep_addr_reg <= '0;
            sweep_val_reg  <= 1'b0;
            is_pixel_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_val_reg  <= sweep_val_next;
            is_pixel_reg   <= is_pixel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_addr_reg <= pix_addr_next;
        bit_sel_reg  <= bit_sel_next;
        color_reg    <= color_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rd_q_reg <= mem[raddr];
        end
    end

endmodule
